FILE: src/rgbbin_pkg.sv
// Shared constants, state encoding and color helper functions for the RGB565 binarizer.
// No dependencies.
package rgbbin_pkg;

	localparam int GRAY_LEVELS = 256;
	localparam int LEVEL_W     = 8;
	localparam int PIX_W       = 16;

	localparam logic [LEVEL_W-1:0] FIX_AUTO = 8'hFF;
	localparam logic [PIX_W-1:0]   WHITE    = 16'hFFFF;
	localparam logic [PIX_W-1:0]   BLACK    = 16'h0000;

	localparam logic [16:0] COEF_R = 17'd13933;
	localparam logic [16:0] COEF_G = 17'd46871;
	localparam logic [16:0] COEF_B = 17'd4732;

	localparam int QUAL_SCALE = 1000;

	// c*255/31 and c*255/63 as reciprocal multiplies, exact over the input range
	localparam logic [31:0] RECIP5 = 32'd138006255;
	localparam logic [31:0] RECIP6 = 32'd67908030;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_EXP  = 11'b000_0000_0010,
		ST_GRAY = 11'b000_0000_0100,
		ST_BIN  = 11'b000_0000_1000,
		ST_RD   = 11'b000_0001_0000,
		ST_WR   = 11'b000_0010_0000,
		ST_SRD  = 11'b000_0100_0000,
		ST_SACC = 11'b000_1000_0000,
		ST_SMUL = 11'b001_0000_0000,
		ST_SCMP = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [31:0] p;
		p = 32'(c) * RECIP5;
		return p[31:24];
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [31:0] p;
		p = 32'(c) * RECIP6;
		return p[31:24];
	endfunction

endpackage

FILE: src/rgb565_auto_threshold_binarize_unit.sv
// Top level of the RGB565 auto-threshold binarizer: histogram memory, threshold search, binarize.
// Depends on rgbbin_pkg.
//
// Usage: an item (req_type, pixel_in, frame_last) is taken at a clock edge with start high
// and busy low. Each result appears for one cycle with done high; the receiver cannot stall.
// A gather pixel (req_type 0) holds busy through expand, gray, histogram read and write back;
// the next beat can be taken once busy is low again.
// Gather gives no result unless frame_last is set; then the threshold search sweeps the
// histogram memory through its two read ports, levels 1 to WINDOW_LEN-1 with read and
// window sum only, and levels WINDOW_LEN to 255 with read, window sum, ratio products and
// compare; a final state latches the threshold and clears the histogram, and done with
// is_threshold high follows.
// A binarize pixel (req_type 1) holds busy through expand, gray and binarize; done comes
// in the first cycle with busy low, pixel_out white or black; the next beat can be taken then.
// busy is high from accept until the result cycle, so one item is in work at a time.
// Configuration: cfg_data is written to fixed_threshold on cfg_valid (cfg_ready always high);
// write it only while idle. Values below 255 override the computed threshold.
// Reset clears the histogram valid bits, pixel count, stored threshold (0) and sets
// fixed_threshold to 255.
module rgb565_auto_threshold_binarize_unit #(
	parameter int WINDOW_LEN       = 40,
	parameter int MAX_FRAME_PIXELS = 16777216
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [rgbbin_pkg::PIX_W-1:0]  pixel_in,
	input  logic                          frame_last,
	output logic                          done,
	output logic [rgbbin_pkg::PIX_W-1:0]  pixel_out,
	output logic [rgbbin_pkg::LEVEL_W-1:0] threshold_out,
	output logic                          is_threshold,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rgbbin_pkg::LEVEL_W-1:0] cfg_data
);
	import rgbbin_pkg::*;

	localparam int BIN_W  = $clog2(MAX_FRAME_PIXELS);
	localparam int CNT_W  = $clog2(2 * MAX_FRAME_PIXELS);
	localparam int SUM_W  = BIN_W + $clog2(WINDOW_LEN + 1);
	localparam int QUAL_W = SUM_W + 10;
	localparam int PROD_W = 2 * SUM_W;
	localparam int EXT_W  = LEVEL_W + 1;

	localparam logic [BIN_W-1:0]   BIN_MAX = BIN_W'(MAX_FRAME_PIXELS - 1);
	localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(2 * MAX_FRAME_PIXELS - 1);
	localparam logic [LEVEL_W-1:0] WIN_LV  = LEVEL_W'(WINDOW_LEN);
	localparam logic [EXT_W-1:0]   WIN_OFS = EXT_W'(WINDOW_LEN - 1);
	localparam logic [EXT_W-1:0]   LV_END  = EXT_W'(GRAY_LEVELS);
	localparam logic [LEVEL_W-1:0] LV_LAST = LEVEL_W'(GRAY_LEVELS - 1);

	state_t state_q;

	logic                   req_q, last_q;
	logic [PIX_W-1:0]       pix_q;
	logic [7:0]             r8_q, g8_q, b8_q;
	logic [LEVEL_W-1:0]     gray_q;
	logic [LEVEL_W-1:0]     fixed_q, auto_q;
	logic [CNT_W-1:0]       count_q;
	logic [GRAY_LEVELS-1:0] valid_q;

	logic [BIN_W-1:0] hist_mem [GRAY_LEVELS];
	logic [BIN_W-1:0] rd_a_q, rd_b_q;
	logic             rd_a_v_q, rd_b_v_q;
	logic [LEVEL_W-1:0] raddr_a, raddr_b;
	logic             mem_we;
	logic [BIN_W-1:0] bin_a, bin_b, bin_inc;

	logic [LEVEL_W-1:0] k_q, best_lvl_q;
	logic [SUM_W-1:0]   acc_q, cur_q, prev_q, acc_next;
	logic [SUM_W-1:0]   num_q, den_q, best_num_q, best_den_q;
	logic [PROD_W-1:0]  lhs_q, rhs_q;
	logic               qual_q;
	logic [EXT_W-1:0]   add_ext;
	logic               add_ok, sub_ok;

	logic [23:0]        gray_sum;
	logic [LEVEL_W-1:0] th_sel;

	logic               done_q, is_th_q;
	logic [PIX_W-1:0]   pix_out_q;
	logic [LEVEL_W-1:0] th_out_q;

	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign pixel_out     = pix_out_q;
	assign threshold_out = th_out_q;
	assign is_threshold  = is_th_q;

	assign gray_sum = 24'(COEF_R) * 24'(r8_q) + 24'(COEF_G) * 24'(g8_q)
	                + 24'(COEF_B) * 24'(b8_q);
	assign th_sel   = (fixed_q < FIX_AUTO) ? fixed_q : auto_q;

	// window slide: level k adds bin k+W-1 and drops bin k-1 once that is at or above W
	assign add_ext = EXT_W'(k_q) + WIN_OFS;
	assign add_ok  = (add_ext < LV_END);
	assign sub_ok  = (k_q > WIN_LV);
	assign raddr_a = (state_q == ST_RD) ? gray_q : add_ext[LEVEL_W-1:0];
	assign raddr_b = k_q - LEVEL_W'(1);

	assign bin_a    = rd_a_v_q ? rd_a_q : '0;
	assign bin_b    = rd_b_v_q ? rd_b_q : '0;
	assign bin_inc  = (bin_a < BIN_MAX) ? bin_a + BIN_W'(1) : bin_a;
	assign mem_we   = (state_q == ST_WR);
	assign acc_next = acc_q + (add_ok ? SUM_W'(bin_a) : '0) - (sub_ok ? SUM_W'(bin_b) : '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[gray_q] <= bin_inc;
		end
		rd_a_q   <= hist_mem[raddr_a];
		rd_b_q   <= hist_mem[raddr_b];
		rd_a_v_q <= valid_q[raddr_a];
		rd_b_v_q <= valid_q[raddr_b];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q  <= req_type;
				pix_q  <= pixel_in;
				last_q <= frame_last;
			end
			ST_EXP: begin
				r8_q <= expand5(pix_q[15:11]);
				g8_q <= expand6(pix_q[10:5]);
				b8_q <= expand5(pix_q[4:0]);
			end
			ST_GRAY: begin
				gray_q <= gray_sum[23:16];
			end
			ST_SACC: begin
				cur_q  <= acc_next;
				prev_q <= acc_q;
			end
			ST_SMUL: begin
				num_q  <= (cur_q == '0) ? SUM_W'(1) : cur_q;
				den_q  <= (prev_q == '0) ? SUM_W'(1) : prev_q;
				lhs_q  <= PROD_W'(((cur_q == '0) ? SUM_W'(1) : cur_q)) * PROD_W'(best_den_q);
				rhs_q  <= PROD_W'(best_num_q) * PROD_W'(((prev_q == '0) ? SUM_W'(1) : prev_q));
				qual_q <= (QUAL_W'(cur_q) * QUAL_W'(QUAL_SCALE)) > QUAL_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fixed_q    <= FIX_AUTO;
			auto_q     <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			k_q        <= '0;
			acc_q      <= '0;
			best_num_q <= '0;
			best_den_q <= SUM_W'(1);
			best_lvl_q <= '0;
			done_q     <= 1'b0;
			is_th_q    <= 1'b0;
			pix_out_q  <= BLACK;
			th_out_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				fixed_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					state_q <= ST_GRAY;
				end
				ST_GRAY: begin
					state_q <= req_q ? ST_BIN : ST_RD;
				end
				ST_BIN: begin
					done_q    <= 1'b1;
					is_th_q   <= 1'b0;
					th_out_q  <= '0;
					pix_out_q <= (gray_q >= th_sel) ? WHITE : BLACK;
					state_q   <= ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					valid_q[gray_q] <= 1'b1;
					if (count_q < CNT_MAX) begin
						count_q <= count_q + CNT_W'(1);
					end
					k_q        <= LEVEL_W'(1);
					acc_q      <= '0;
					best_num_q <= '0;
					best_den_q <= SUM_W'(1);
					best_lvl_q <= '0;
					state_q    <= last_q ? ST_SRD : ST_IDLE;
				end
				ST_SRD: begin
					state_q <= ST_SACC;
				end
				ST_SACC: begin
					acc_q <= acc_next;
					if (k_q < WIN_LV) begin
						k_q     <= k_q + LEVEL_W'(1);
						state_q <= ST_SRD;
					end else begin
						state_q <= ST_SMUL;
					end
				end
				ST_SMUL: begin
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if ((lhs_q > rhs_q) && qual_q) begin
						best_num_q <= num_q;
						best_den_q <= den_q;
						best_lvl_q <= k_q;
					end
					if (k_q == LV_LAST) begin
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_q + LEVEL_W'(1);
						state_q <= ST_SRD;
					end
				end
				ST_DONE: begin
					auto_q    <= best_lvl_q;
					done_q    <= 1'b1;
					is_th_q   <= 1'b1;
					th_out_q  <= best_lvl_q;
					pix_out_q <= BLACK;
					valid_q   <= '0;
					count_q   <= '0;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without work in progress");

	a_th_beat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_threshold) |-> (pixel_out == BLACK && threshold_out == auto_q))
		else $error("threshold beat fields wrong");

	a_pix_beat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_threshold) |-> ((pixel_out == WHITE || pixel_out == BLACK)
			&& threshold_out == '0))
		else $error("pixel beat fields wrong");

	a_hist_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (valid_q == '0 && count_q == '0))
		else $error("histogram not cleared after search");

endmodule
